// File: rtl/core/assert_macros.svh
// assertion helper macros used by the top-level rtl file
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/core/lsfs_pkg.sv
// shared types and codes of the linear sensor frame sequencer
// no dependencies
package lsfs_pkg;

    // input opcodes
    localparam logic [1:0] OP_RISE = 2'd0;
    localparam logic [1:0] OP_FALL = 2'd1;
    localparam logic [1:0] OP_HOST = 2'd2;

    // host command words
    localparam logic [15:0] MSG_FRAME  = 16'd3;
    localparam logic [15:0] MSG_PIXELS = 16'd4;
    localparam logic [15:0] MSG_PERIOD = 16'd5;

    localparam logic [15:0] PIXELS_MAX = 16'd65534;

    // result word kinds
    localparam logic [2:0] KIND_PIN        = 3'd0;
    localparam logic [2:0] KIND_SAMPLE     = 3'd1;
    localparam logic [2:0] KIND_HDR_PIXELS = 3'd2;
    localparam logic [2:0] KIND_HDR_PERIOD = 3'd3;
    localparam logic [2:0] KIND_ECHO       = 3'd4;

    // input item without the sample, whose width is a parameter
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] message;
        logic [15:0] argument;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        start_pulse;
        logic        last;
    } word_t;

    // one or two result words caused by one item
    typedef struct packed {
        word_t w0;
        word_t w1;
        logic  two;
    } result_t;

endpackage

// File: rtl/core/linear_sensor_frame_sequencer_top.sv
// top level of the linear sensor frame sequencer
// depends on lsfs_pkg, lsfs_in_stage, lsfs_core, lsfs_out_buf, assert_macros.svh
//
// Usage: each word on the s_ channel is a rising sensor clock tick with an
// ADC sample (opcode 0), a falling tick (opcode 1) or a host command
// (opcode 2). Every input word yields one or two result words on the m_
// channel; m_last marks the final one. A frame start yields two header
// words (pixel count, then period), everything else yields one word.
// An input word is registered, processed by the sequencer state logic
// and written to a two-entry result register, from which its first
// result is shown on the m_ ports. Throughput is one input word per
// cycle while each word yields one result and the receiver takes every
// word; a header holds the input while the single output port drains
// its two words.
// m_start_pulse is the level for the sensor start and hold pins.
// Reset (aresetn low, synchronous) empties both registers, clears the tick
// counter and flags and loads the default pixel count and period.
// When the receiver stalls, results stay in the output register and the
// input stage fills, after which s_ready drops; nothing is lost.
`include "assert_macros.svh"

module linear_sensor_frame_sequencer_top
    import lsfs_pkg::*;
#(
    parameter int DEFAULT_PIXELS = 128,
    parameter int SAMPLE_BITS    = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_opcode,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  logic [15:0]            s_message,
    input  logic [15:0]            s_argument,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_word_kind,
    output logic [15:0]            m_word_value,
    output logic                   m_start_pulse,
    output logic                   m_last
);

    item_t                  s_item;
    item_t                  item;
    logic [SAMPLE_BITS-1:0] item_sample;
    logic                   item_vld;
    logic                   load_ready;
    logic                   take;
    result_t                result;
    word_t                  head;

    assign s_item = '{opcode: s_opcode, message: s_message, argument: s_argument};
    assign take   = item_vld && load_ready;

    lsfs_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .s_sample    (s_sample),
        .item_vld    (item_vld),
        .item        (item),
        .item_sample (item_sample),
        .item_take   (take)
    );

    lsfs_core #(
        .DEFAULT_PIXELS (DEFAULT_PIXELS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .item        (item),
        .item_sample (item_sample),
        .result      (result)
    );

    lsfs_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (take),
        .result     (result),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_word_kind   = head.kind;
    assign m_word_value  = head.value;
    assign m_start_pulse = head.start_pulse;
    assign m_last        = head.last;

    // only the first header word is ever shown without last
    `ASSERT_PROP(a_first_of_pair, aclk, aresetn,
        (m_valid && !m_last) |-> (m_word_kind == KIND_HDR_PIXELS))

    // a taken header pixel word is followed by the period word
    `ASSERT_PROP(a_header_order, aclk, aresetn,
        (m_valid && m_ready && m_word_kind == KIND_HDR_PIXELS)
            |=> (m_valid && m_word_kind == KIND_HDR_PERIOD && m_last))

    // input stage stalls only while it holds a word the core cannot take
    `ASSERT_NEVER(a_stall_reason, aclk, aresetn,
        !s_ready && (!item_vld || load_ready))

endmodule

// File: rtl/core/lsfs_in_stage.sv
// input register stage: holds one accepted item until the core takes it
// depends on lsfs_pkg
module lsfs_in_stage
    import lsfs_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  item_t                  s_item,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   item_vld,
    output item_t                  item,
    output logic [SAMPLE_BITS-1:0] item_sample,
    input  logic                   item_take
);

    logic                   vld_reg;
    logic                   vld_next;
    item_t                  item_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    // accept when empty or when the held word leaves in the same cycle
    assign s_ready  = !vld_reg || item_take;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg   <= s_item;
            sample_reg <= s_sample;
        end
    end

    assign item_vld    = vld_reg;
    assign item        = item_reg;
    assign item_sample = sample_reg;

endmodule

// File: rtl/core/lsfs_core.sv
// sequencer state and per-item decision logic
// depends on lsfs_pkg
module lsfs_core
    import lsfs_pkg::*;
#(
    parameter int DEFAULT_PIXELS = 128,
    parameter int SAMPLE_BITS    = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  item_t                  item,
    input  logic [SAMPLE_BITS-1:0] item_sample,
    output result_t                result
);

    localparam logic [15:0] PIX_RST = 16'(DEFAULT_PIXELS);
    localparam logic [15:0] PER_RST = 16'(DEFAULT_PIXELS + 1);

    logic [15:0] tick_reg,       tick_next;
    logic [15:0] pix_act_reg,    pix_act_next;
    logic [15:0] per_act_reg,    per_act_next;
    logic [15:0] pix_pend_reg,   pix_pend_next;
    logic [15:0] per_pend_reg,   per_pend_next;
    logic        requested_reg,  requested_next;
    logic        sending_reg,    sending_next;
    logic        pulse_reg,      pulse_next;

    logic [16:0] tick_inc;
    logic [15:0] pix_inc;
    logic [15:0] per_fixed;

    assign tick_inc  = {1'b0, tick_reg} + 17'd1;
    // pending pixel count never exceeds 65534, so this fits
    assign pix_inc   = pix_pend_reg + 16'd1;
    assign per_fixed = (per_pend_reg < pix_inc) ? pix_inc : per_pend_reg;

    always_comb begin
        tick_next      = tick_reg;
        pix_act_next   = pix_act_reg;
        per_act_next   = per_act_reg;
        pix_pend_next  = pix_pend_reg;
        per_pend_next  = per_pend_reg;
        requested_next = requested_reg;
        sending_next   = sending_reg;
        pulse_next     = pulse_reg;
        result.two     = 1'b0;
        result.w0      = '{kind: KIND_PIN, value: 16'd0, start_pulse: 1'b0, last: 1'b1};
        result.w1      = '{kind: KIND_HDR_PERIOD, value: 16'd0, start_pulse: 1'b0,
                           last: 1'b1};

        case (item.opcode)
            OP_RISE: begin
                if (tick_inc >= {1'b0, per_act_reg}) begin
                    tick_next    = 16'd0;
                    sending_next = 1'b0;
                end else begin
                    tick_next = tick_inc[15:0];
                    if (tick_inc[15:0] <= pix_act_reg && sending_reg) begin
                        result.w0.kind  = KIND_SAMPLE;
                        result.w0.value = 16'(item_sample);
                    end
                end
            end
            OP_FALL: begin
                pulse_next = (tick_reg == 16'd0);
                if (pulse_next && requested_reg) begin
                    requested_next  = 1'b0;
                    sending_next    = 1'b1;
                    per_pend_next   = per_fixed;
                    pix_act_next    = pix_pend_reg;
                    per_act_next    = per_fixed;
                    result.two      = 1'b1;
                    result.w0.kind  = KIND_HDR_PIXELS;
                    result.w0.value = pix_pend_reg;
                    result.w0.last  = 1'b0;
                    result.w1.value = per_fixed;
                end
            end
            OP_HOST: begin
                if (item.message == MSG_FRAME) begin
                    requested_next = 1'b1;
                end else if (item.message == MSG_PIXELS) begin
                    pix_pend_next = (item.argument > PIXELS_MAX) ? PIXELS_MAX
                                                                 : item.argument;
                end else if (item.message == MSG_PERIOD) begin
                    per_pend_next = item.argument;
                end else begin
                    result.w0.kind  = KIND_ECHO;
                    result.w0.value = item.message;
                end
            end
            default: begin
                // unused opcode: quiet word, no state change
            end
        endcase

        result.w0.start_pulse = pulse_next;
        result.w1.start_pulse = pulse_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= 16'd0;
            pix_act_reg   <= PIX_RST;
            per_act_reg   <= PER_RST;
            pix_pend_reg  <= PIX_RST;
            per_pend_reg  <= PER_RST;
            requested_reg <= 1'b0;
            sending_reg   <= 1'b0;
            pulse_reg     <= 1'b0;
        end else if (take) begin
            tick_reg      <= tick_next;
            pix_act_reg   <= pix_act_next;
            per_act_reg   <= per_act_next;
            pix_pend_reg  <= pix_pend_next;
            per_pend_reg  <= per_pend_next;
            requested_reg <= requested_next;
            sending_reg   <= sending_next;
            pulse_reg     <= pulse_next;
        end
    end

endmodule

// File: rtl/core/lsfs_out_buf.sv
// two-entry result register feeding the output channel
// depends on lsfs_pkg
module lsfs_out_buf
    import lsfs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    load_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output word_t   head
);

    logic [1:0] cnt_reg, cnt_next;
    word_t      w0_reg,  w0_next;
    word_t      w1_reg,  w1_next;

    assign m_valid    = (cnt_reg != 2'd0);
    // a new pair may land once the last held word is leaving
    assign load_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign head       = w0_reg;

    always_comb begin
        cnt_next = cnt_reg;
        w0_next  = w0_reg;
        w1_next  = w1_reg;
        if (load) begin
            w0_next  = result.w0;
            w1_next  = result.w1;
            cnt_next = result.two ? 2'd2 : 2'd1;
        end else if (m_valid && m_ready) begin
            if (cnt_reg == 2'd2) begin
                w0_next  = w1_reg;
                cnt_next = 2'd1;
            end else begin
                cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        w0_reg <= w0_next;
        w1_reg <= w1_next;
    end

endmodule

// File: tb/tb_linear_sensor_frame_sequencer_top.sv
// testbench for linear_sensor_frame_sequencer_top: directed and random tick/host words,
// a per-word predictor of the sequencer state and a word-by-word result check
// depends on lsfs_pkg and the rtl of linear_sensor_frame_sequencer_top
module tb_linear_sensor_frame_sequencer_top;
    import lsfs_pkg::*;

    localparam int NPIX_DEFAULT  = 128;
    localparam int SMP_W         = 10;
    localparam int WATCHDOG_IDLE = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 600;
    localparam int RANDOM_TARGET = 1300;

    typedef struct {
        logic [1:0]       opcode;
        logic [SMP_W-1:0] sample;
        logic [15:0]      message;
        logic [15:0]      argument;
        bit               wait_drained;
    } seq_input_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode      = '0;
    logic [SMP_W-1:0]  s_sample      = '0;
    logic [15:0]       s_message     = '0;
    logic [15:0]       s_argument    = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [2:0]        m_word_kind;
    logic [15:0]       m_word_value;
    logic              m_start_pulse;
    logic              m_last;

    // predicted sequencer state
    logic [15:0] ticks          = '0;
    logic [15:0] pixels_now     = 16'(NPIX_DEFAULT);
    logic [15:0] period_now     = 16'(NPIX_DEFAULT + 1);
    logic [15:0] pixels_next    = 16'(NPIX_DEFAULT);
    logic [15:0] period_next    = 16'(NPIX_DEFAULT + 1);
    logic        frame_wanted   = 1'b0;
    logic        frame_running  = 1'b0;
    logic        pin_level      = 1'b0;

    seq_input_t pending_inputs[$];
    word_t      expected_words[$];

    int inputs_accepted = 0;
    int total_inputs    = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int rx_cycle        = 0;
    int rx_mode         = 0;
    int hold_left       = 0;
    bit long_hold_done  = 1'b0;

    linear_sensor_frame_sequencer_top #(
        .DEFAULT_PIXELS(NPIX_DEFAULT),
        .SAMPLE_BITS   (SMP_W)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_sample     (s_sample),
        .s_message    (s_message),
        .s_argument   (s_argument),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_kind  (m_word_kind),
        .m_word_value (m_word_value),
        .m_start_pulse(m_start_pulse),
        .m_last       (m_last)
    );

    always #1 aclk = ~aclk;

    function automatic void queue_input(logic [1:0] op, logic [SMP_W-1:0] smp,
                                        logic [15:0] msg, logic [15:0] arg,
                                        bit hold = 1'b0);
        seq_input_t it;
        it.opcode       = op;
        it.sample       = smp;
        it.message      = msg;
        it.argument     = arg;
        it.wait_drained = hold;
        pending_inputs.push_back(it);
    endfunction

    // any host word that is not a command
    function automatic logic [15:0] echo_word();
        logic [15:0] w;
        w = 16'($urandom);
        if (w >= MSG_FRAME && w <= MSG_PERIOD)
            w = w ^ 16'h0100;
        return w;
    endfunction

    function automatic void push_word(logic [2:0] kind, logic [15:0] value, logic last);
        word_t w;
        w.kind        = kind;
        w.value       = value;
        w.start_pulse = pin_level;
        w.last        = last;
        expected_words.push_back(w);
    endfunction

    // advance the sequencer state by one word and queue the result words it causes
    function automatic void predict_words(logic [1:0] op, logic [SMP_W-1:0] smp,
                                          logic [15:0] msg, logic [15:0] arg);
        logic [16:0] next_tick;
        next_tick = {1'b0, ticks} + 17'd1;
        case (op)
            OP_RISE: begin
                if (next_tick >= {1'b0, period_now}) begin
                    ticks         = '0;
                    frame_running = 1'b0;
                end else begin
                    ticks = next_tick[15:0];
                    if (ticks <= pixels_now && frame_running) begin
                        push_word(KIND_SAMPLE, 16'(smp), 1'b1);
                        return;
                    end
                end
            end
            OP_FALL: begin
                pin_level = (ticks == 16'd0);
                if (pin_level && frame_wanted) begin
                    frame_wanted  = 1'b0;
                    frame_running = 1'b1;
                    if ({1'b0, period_next} < {1'b0, pixels_next} + 17'd1)
                        period_next = pixels_next + 16'd1;
                    pixels_now = pixels_next;
                    period_now = period_next;
                    push_word(KIND_HDR_PIXELS, pixels_now, 1'b0);
                    push_word(KIND_HDR_PERIOD, period_now, 1'b1);
                    return;
                end
            end
            OP_HOST: begin
                if (msg == MSG_FRAME) begin
                    frame_wanted = 1'b1;
                end else if (msg == MSG_PIXELS) begin
                    pixels_next = (arg > PIXELS_MAX) ? PIXELS_MAX : arg;
                end else if (msg == MSG_PERIOD) begin
                    period_next = arg;
                end else begin
                    push_word(KIND_ECHO, msg, 1'b1);
                    return;
                end
            end
            default: ;
        endcase
        push_word(KIND_PIN, 16'd0, 1'b1);
    endfunction

    function automatic void note_mismatch(string what, word_t want, word_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("result error (%s): expected kind %0d value %0d pulse %0d last %0d",
                     what, want.kind, want.value, want.start_pulse, want.last);
            $display("    got kind %0d value %0d pulse %0d last %0d",
                     got.kind, got.value, got.start_pulse, got.last);
        end
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        seq_input_t it;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_words(s_opcode, s_sample, s_message, s_argument);
                inputs_accepted <= inputs_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_inputs.size() == 0 ||
                             (pending_inputs[0].wait_drained && expected_words.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    it = pending_inputs.pop_front();
                    s_opcode   <= it.opcode;
                    s_sample   <= it.sample;
                    s_message  <= it.message;
                    s_argument <= it.argument;
                    s_valid    <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: randomly chosen stall patterns, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                rx_mode <= $urandom_range(0, 3);
            if (!long_hold_done && inputs_accepted >= HOLD_AFTER) begin
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD;
                m_ready        <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 9) != 0);
                    default: m_ready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    // result check against the oldest predicted word
    always @(posedge aclk) begin
        word_t got;
        word_t want;
        if (aresetn && m_valid && m_ready) begin
            got.kind        = m_word_kind;
            got.value       = m_word_value;
            got.start_pulse = m_start_pulse;
            got.last        = m_last;
            if (expected_words.size() == 0) begin
                want = '0;
                note_mismatch("no word expected", want, got);
            end else begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.value !== want.value ||
                    got.start_pulse !== want.start_pulse || got.last !== want.last)
                    note_mismatch("field", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_IDLE) begin
            $display("linear_sensor_frame_sequencer_top: mismatch");
            $finish;
        end
    end

    initial begin
        int pix;
        int per;
        int span;
        int nticks;
        int n;
        logic [1:0]  op;
        logic [15:0] msg;
        logic [15:0] arg;

        // frame with the reset pixel count and period, run until the counter wraps
        queue_input(OP_HOST, '0, MSG_FRAME, '0);
        queue_input(OP_FALL, '1, '1, '1);
        for (int k = 0; k < NPIX_DEFAULT + 1; k++) begin
            queue_input(OP_RISE, SMP_W'($urandom), 16'($urandom), 16'($urandom));
            if (k % 16 == 5)
                queue_input(OP_FALL, SMP_W'($urandom), 16'($urandom), 16'($urandom));
        end

        // short period is raised to pixels plus one
        queue_input(OP_HOST, '0, MSG_PIXELS, 16'd2);
        queue_input(OP_HOST, '0, MSG_PERIOD, 16'd0);
        queue_input(OP_HOST, '0, MSG_FRAME, '0);
        queue_input(OP_FALL, '0, '0, '0);
        queue_input(OP_RISE, '0, '0, '0);
        queue_input(OP_FALL, '0, '0, '0);
        queue_input(OP_RISE, '1, '1, '1);
        queue_input(OP_RISE, '0, '0, '0);
        queue_input(OP_FALL, '0, '0, '0);
        queue_input(2'd3, '1, '1, '1);
        queue_input(OP_HOST, '0, 16'd0, '0);
        queue_input(OP_HOST, '1, 16'hFFFF, '1);
        queue_input(OP_HOST, '0, 16'd6, '0, 1'b1);
        // oversized settings, overwritten before the next frame
        queue_input(OP_HOST, '0, MSG_PIXELS, 16'hFFFF);
        queue_input(OP_HOST, '0, MSG_PERIOD, 16'hFFFF);
        queue_input(OP_HOST, '0, MSG_PIXELS, 16'd3);
        queue_input(OP_HOST, '0, MSG_PERIOD, 16'd5);
        queue_input(OP_HOST, '0, MSG_FRAME, '0);
        queue_input(OP_FALL, '0, '0, '0);
        for (int k = 0; k < 5; k++)
            queue_input(OP_RISE, SMP_W'($urandom), '0, '0);

        while (pending_inputs.size() < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                6, 7: begin
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++) begin
                        op  = 2'($urandom_range(0, 3));
                        msg = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(3, 5))
                                                          : 16'($urandom);
                        arg = 16'($urandom);
                        if (op == OP_HOST && (msg == MSG_PIXELS || msg == MSG_PERIOD))
                            arg = 16'($urandom_range(0, 12));
                        queue_input(op, SMP_W'($urandom), msg, arg);
                    end
                end
                8: begin
                    queue_input(OP_HOST, '0, MSG_PIXELS, 16'($urandom));
                    queue_input(OP_HOST, '0, MSG_PERIOD, 16'($urandom));
                    queue_input(OP_HOST, '0, MSG_PIXELS, 16'($urandom_range(0, 6)));
                    queue_input(OP_HOST, '0, MSG_PERIOD, 16'($urandom_range(0, 10)));
                end
                9: begin
                    queue_input(OP_HOST, SMP_W'($urandom), echo_word(), 16'($urandom), 1'b1);
                end
                default: begin
                    pix = $urandom_range(0, 6);
                    if ($urandom_range(0, 7) == 0)
                        pix = $urandom_range(7, 24);
                    per = $urandom_range(0, pix + 8);
                    if ($urandom_range(0, 3) != 0) begin
                        queue_input(OP_HOST, '0, MSG_PIXELS, 16'(pix));
                        queue_input(OP_HOST, '0, MSG_PERIOD, 16'(per));
                    end
                    queue_input(OP_HOST, SMP_W'($urandom), MSG_FRAME, 16'($urandom));
                    span   = (per > pix) ? per : pix + 1;
                    nticks = $urandom_range(span, 3 * span + 30);
                    for (int k = 0; k < nticks; k++) begin
                        queue_input(OP_RISE, SMP_W'($urandom), 16'($urandom), 16'($urandom));
                        case ($urandom_range(0, 15))
                            0: ;
                            1: begin
                                queue_input(OP_HOST, '0, MSG_FRAME, '0);
                                queue_input(OP_FALL, SMP_W'($urandom), 16'($urandom),
                                            16'($urandom));
                            end
                            2: queue_input(OP_HOST, '0, echo_word(), 16'($urandom));
                            default: queue_input(OP_FALL, SMP_W'($urandom), 16'($urandom),
                                                 16'($urandom));
                        endcase
                    end
                end
            endcase
        end

        // saturated pixel count; period raised to its maximum, so this frame closes the run
        queue_input(OP_HOST, '0, MSG_PIXELS, 16'hFFFF);
        queue_input(OP_HOST, '0, MSG_PERIOD, 16'd7);
        queue_input(OP_HOST, '0, MSG_FRAME, '0);
        for (int k = 0; k < 40; k++) begin
            queue_input(OP_RISE, SMP_W'($urandom), 16'($urandom), 16'($urandom));
            queue_input(OP_FALL, SMP_W'($urandom), 16'($urandom), 16'($urandom));
        end

        total_inputs = pending_inputs.size();

        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (inputs_accepted != total_inputs)
            @(posedge aclk);
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("linear_sensor_frame_sequencer_top: match");
        else
            $display("linear_sensor_frame_sequencer_top: mismatch");
        $finish;
    end

endmodule
